[rtl/spdf_pkg.sv]
// Types, codes and helpers shared by the senior priority dual FIFO block.
`default_nettype none

package spdf_pkg;

  // Queue geometry
  localparam int QUEUE_DEPTH = 8;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int CNT_OUT_W   = 4;

  // Reset value of the age threshold register
  localparam logic [7:0] AGE_THRESHOLD_RESET = 8'd60;

  // Operation codes
  localparam logic [1:0] FN_INSERT   = 2'd0;
  localparam logic [1:0] FN_POP_PRIO = 2'd1;
  localparam logic [1:0] FN_POP_NORM = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_PRIO     = 3'd0;
  localparam logic [2:0] ST_NORM     = 3'd1;
  localparam logic [2:0] ST_REJECTED = 3'd2;
  localparam logic [2:0] ST_REMOVED  = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;

  // One stored person record
  typedef struct packed {
    logic signed [31:0] key;
    logic [7:0]         age;
    logic [9:0]         weight;
    logic [39:0]        salary_cents;
  } rec_t;

  // One accepted input beat
  typedef struct packed {
    logic [1:0] func;
    rec_t       rec;
  } item_t;

  // One result beat
  typedef struct packed {
    logic [2:0]           status;
    rec_t                 rec;
    logic [CNT_OUT_W-1:0] priority_count;
    logic [CNT_OUT_W-1:0] normal_count;
  } res_t;

  // Queue control and status
  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             full;
    logic             empty;
  } q_stat_t;

  // Advance a ring pointer, wrapping at the queue depth
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

`default_nettype wire

[rtl/spdf_ifs.sv]
// Handshake channel interfaces: input items, results and configuration writes.
`default_nettype none

interface spdf_in_if import spdf_pkg::*;;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic signed [31:0] key;
  logic [7:0]         age;
  logic [9:0]         weight;
  logic [39:0]        salary_cents;

  modport source (output valid, func, key, age, weight, salary_cents, input ready);
  modport sink   (input valid, func, key, age, weight, salary_cents, output ready);
endinterface

interface spdf_out_if import spdf_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [2:0]           status;
  logic signed [31:0]   out_key;
  logic [7:0]           out_age;
  logic [9:0]           out_weight;
  logic [39:0]          out_salary_cents;
  logic [CNT_OUT_W-1:0] priority_count;
  logic [CNT_OUT_W-1:0] normal_count;

  modport source (output valid, status, out_key, out_age, out_weight, out_salary_cents,
                  priority_count, normal_count, input ready);
  modport sink   (input valid, status, out_key, out_age, out_weight, out_salary_cents,
                  priority_count, normal_count, output ready);
endinterface

interface spdf_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

[rtl/senior_priority_dual_fifo_unit.sv]
// Top level: routes records into a priority or a normal queue and pops them on request.
//
//  Channel  Role  Carries
//  in_ch    sink  func, key, age, weight, salary_cents
//  out_ch   src   status, out_key, out_age, out_weight, out_salary_cents, both counts
//  cfg      sink  data: age_threshold (always ready)
//
// One item per cycle while results are taken; each item passes the input register, then
// the queue update and the result buffer write, which happen in the same cycle.
// Synchronous reset empties both queues and sets age_threshold to 60.
// A stalled result sink fills the two-entry result buffer and then the input register;
// in_ch.ready stays low from then until the cycle after a result beat is taken.
`default_nettype none

module senior_priority_dual_fifo_unit import spdf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  spdf_in_if.sink    in_ch,
  spdf_out_if.source out_ch,
  spdf_cfg_if.sink   cfg
);

  logic       [7:0] age_threshold;
  item_t            s1;
  logic             s1_valid;
  logic             s1_advance;
  logic             res_space;
  q_ctrl_t          prio_ctrl;
  q_ctrl_t          norm_ctrl;
  q_stat_t          prio_stat;
  q_stat_t          norm_stat;
  rec_t             prio_head;
  rec_t             norm_head;
  res_t             res;
  logic [CNT_W-1:0] prio_after;
  logic [CNT_W-1:0] norm_after;

  // Hold the threshold register
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      age_threshold <= AGE_THRESHOLD_RESET;
    end else if (cfg.valid) begin
      age_threshold <= cfg.data;
    end
  end

  // Input register
  assign s1_advance  = s1_valid && res_space;
  assign in_ch.ready = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1.func             <= in_ch.func;
      s1.rec.key          <= in_ch.key;
      s1.rec.age          <= in_ch.age;
      s1.rec.weight       <= in_ch.weight;
      s1.rec.salary_cents <= in_ch.salary_cents;
    end
  end

  // Decode the operation and route the record
  always_comb begin
    prio_ctrl  = '0;
    norm_ctrl  = '0;
    res.status = ST_EMPTY;
    res.rec    = '0;
    unique case (s1.func)
      FN_INSERT: begin
        if (s1.rec.age >= age_threshold && !prio_stat.full) begin
          prio_ctrl.push = s1_advance;
          res.status     = ST_PRIO;
        end else if (!norm_stat.full) begin
          norm_ctrl.push = s1_advance;
          res.status     = ST_NORM;
        end else begin
          res.status = ST_REJECTED;
        end
      end
      FN_POP_PRIO: begin
        if (!prio_stat.empty) begin
          prio_ctrl.pop = s1_advance;
          res.status    = ST_REMOVED;
          res.rec       = prio_head;
        end
      end
      FN_POP_NORM: begin
        if (!norm_stat.empty) begin
          norm_ctrl.pop = s1_advance;
          res.status    = ST_REMOVED;
          res.rec       = norm_head;
        end
      end
      default: begin
        res.status = ST_EMPTY;
      end
    endcase
    prio_after = prio_stat.count + CNT_W'(prio_ctrl.push) - CNT_W'(prio_ctrl.pop);
    norm_after = norm_stat.count + CNT_W'(norm_ctrl.push) - CNT_W'(norm_ctrl.pop);
    res.priority_count = CNT_OUT_W'(prio_after);
    res.normal_count   = CNT_OUT_W'(norm_after);
  end

  spdf_queue u_prio_q (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (prio_ctrl),
    .push_rec (s1.rec),
    .head_rec (prio_head),
    .stat     (prio_stat)
  );

  spdf_queue u_norm_q (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (norm_ctrl),
    .push_rec (s1.rec),
    .head_rec (norm_head),
    .stat     (norm_stat)
  );

  spdf_out_buf u_out_buf (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (s1_advance),
    .wr_data (res),
    .space   (res_space),
    .out_ch  (out_ch)
  );

  // Stall the input while a held item has nowhere to go
  a_stall_when_full: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !res_space) |-> !in_ch.ready)
    else $error("input accepted while result buffer full");

  // Occupancy never exceeds the queue depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (prio_stat.count <= CNT_W'(QUEUE_DEPTH)) && (norm_stat.count <= CNT_W'(QUEUE_DEPTH)))
    else $error("queue occupancy beyond depth");

  // A push to the priority queue raises its count by one
  a_prio_push_count: assert property (@(posedge clk) disable iff (rst)
    prio_ctrl.push |=> (prio_stat.count == $past(prio_stat.count) + 1'b1))
    else $error("priority count did not follow push");

  // A pop from the normal queue lowers its count by one
  a_norm_pop_count: assert property (@(posedge clk) disable iff (rst)
    norm_ctrl.pop |=> (norm_stat.count == $past(norm_stat.count) - 1'b1))
    else $error("normal count did not follow pop");

endmodule

`default_nettype wire

[rtl/spdf_queue.sv]
// Circular record queue with head, tail and occupancy count.
`default_nettype none

module spdf_queue import spdf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  q_ctrl_t ctrl,
  input  rec_t    push_rec,
  output rec_t    head_rec,
  output q_stat_t stat
);

  rec_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [CNT_W-1:0] count;

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (ctrl.push) tail <= ptr_inc(tail);
      if (ctrl.pop)  head <= ptr_inc(head);
      case ({ctrl.push, ctrl.pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Store the pushed record at the tail
  always_ff @(posedge clk) begin
    if (ctrl.push) mem[tail] <= push_rec;
  end

  // Present head entry and occupancy
  assign head_rec   = mem[head];
  assign stat.count = count;
  assign stat.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);

endmodule

`default_nettype wire

[rtl/spdf_out_buf.sv]
// Two-entry result buffer that decouples result delivery from item acceptance.
`default_nettype none

module spdf_out_buf import spdf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  res_t        wr_data,
  output logic        space,
  spdf_out_if.source  out_ch
);

  res_t       slot0;
  res_t       slot1;
  logic [1:0] fill;
  logic       pop;

  assign pop = out_ch.valid && out_ch.ready;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
    end else begin
      case ({wr_en, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  // Move result beats through the two slots
  always_ff @(posedge clk) begin
    if (pop) begin
      slot0 <= (fill == 2'd2) ? slot1 : wr_data;
    end else if (wr_en && fill == 2'd0) begin
      slot0 <= wr_data;
    end
    if (wr_en && !pop && fill == 2'd1) slot1 <= wr_data;
  end

  assign space                   = (fill != 2'd2);
  assign out_ch.valid            = (fill != 2'd0);
  assign out_ch.status           = slot0.status;
  assign out_ch.out_key          = slot0.rec.key;
  assign out_ch.out_age          = slot0.rec.age;
  assign out_ch.out_weight       = slot0.rec.weight;
  assign out_ch.out_salary_cents = slot0.rec.salary_cents;
  assign out_ch.priority_count   = slot0.priority_count;
  assign out_ch.normal_count     = slot0.normal_count;

endmodule

`default_nettype wire

[test/spdf_checker.sv]
// Checker for the senior priority dual FIFO: tracks both queues, predicts each result and compares.
module spdf_checker import spdf_pkg::*; (
  input  logic clk,
  input  logic rst,
  spdf_in_if   in_ch,
  spdf_out_if  out_ch,
  spdf_cfg_if  cfg,
  output int   failures,
  output int   pending
);

  // Shadow copy of both ring buffers and the routing threshold
  rec_t        prio_slots [QUEUE_DEPTH];
  rec_t        norm_slots [QUEUE_DEPTH];
  int unsigned prio_head;
  int unsigned prio_fill;
  int unsigned norm_head;
  int unsigned norm_fill;
  logic [7:0]  age_threshold;
  res_t        awaited [$];

  // Apply one request to the shadow queues and return the result it should produce
  function automatic res_t route_record(input item_t req);
    res_t res;
    res        = '0;
    res.status = ST_EMPTY;
    case (req.func)
      FN_INSERT: begin
        if (req.rec.age >= age_threshold && prio_fill < QUEUE_DEPTH) begin
          prio_slots[(prio_head + prio_fill) % QUEUE_DEPTH] = req.rec;
          prio_fill++;
          res.status = ST_PRIO;
        end else if (norm_fill < QUEUE_DEPTH) begin
          norm_slots[(norm_head + norm_fill) % QUEUE_DEPTH] = req.rec;
          norm_fill++;
          res.status = ST_NORM;
        end else begin
          res.status = ST_REJECTED;
        end
      end
      FN_POP_PRIO: begin
        if (prio_fill != 0) begin
          res.rec    = prio_slots[prio_head];
          prio_head  = (prio_head + 1) % QUEUE_DEPTH;
          prio_fill--;
          res.status = ST_REMOVED;
        end
      end
      FN_POP_NORM: begin
        if (norm_fill != 0) begin
          res.rec    = norm_slots[norm_head];
          norm_head  = (norm_head + 1) % QUEUE_DEPTH;
          norm_fill--;
          res.status = ST_REMOVED;
        end
      end
      // the spare operation code leaves everything untouched
      default: ;
    endcase
    res.priority_count = CNT_OUT_W'(prio_fill);
    res.normal_count   = CNT_OUT_W'(norm_fill);
    return res;
  endfunction

  // Report one field that disagrees
  function automatic int field_differs(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // Predict on each accepted request beat, compare on each accepted result beat
  always @(posedge clk) begin
    item_t req;
    res_t  want;
    int    errs;
    errs = 0;
    if (rst) begin
      prio_head     = 0;
      prio_fill     = 0;
      norm_head     = 0;
      norm_fill     = 0;
      age_threshold = AGE_THRESHOLD_RESET;
      awaited.delete();
      failures <= 0;
      pending  <= 0;
    end else begin
      if (cfg.valid && cfg.ready) age_threshold = cfg.data;

      if (in_ch.valid && in_ch.ready) begin
        req.func             = in_ch.func;
        req.rec.key          = in_ch.key;
        req.rec.age          = in_ch.age;
        req.rec.weight       = in_ch.weight;
        req.rec.salary_cents = in_ch.salary_cents;
        awaited.push_back(route_record(req));
      end

      if (out_ch.valid && out_ch.ready) begin
        if (awaited.size() == 0) begin
          $error("result beat arrived with no request outstanding");
          errs++;
        end else begin
          want = awaited.pop_front();
          errs += field_differs("status", want.status, out_ch.status);
          errs += field_differs("out_key", want.rec.key, out_ch.out_key);
          errs += field_differs("out_age", want.rec.age, out_ch.out_age);
          errs += field_differs("out_weight", want.rec.weight, out_ch.out_weight);
          errs += field_differs("out_salary_cents", want.rec.salary_cents,
                                out_ch.out_salary_cents);
          errs += field_differs("priority_count", want.priority_count, out_ch.priority_count);
          errs += field_differs("normal_count", want.normal_count, out_ch.normal_count);
        end
      end

      failures <= failures + errs;
      pending  <= awaited.size();
    end
  end

endmodule

[test/tb_senior_priority_dual_fifo_unit.sv]
// Testbench top for the senior priority dual FIFO: stimulus, idling, watchdog and verdict.
module tb_senior_priority_dual_fifo_unit;
  import spdf_pkg::*;

  localparam logic [1:0] FN_UNUSED    = 2'd3;
  localparam int         RESET_CYCLES = 7;
  localparam int         PHASE_ITEMS  = 400;
  localparam int         STALL_LIMIT  = 2000;
  localparam int         DRAIN_CYCLES = 8;

  // Ages for the directed fill: eight eligible ones, then a mix that ends up in the normal queue
  localparam logic [7:0] DIRECTED_AGES [16] = '{8'd60, 8'd255, 8'd61, 8'd200, 8'd60, 8'd99,
                                               8'd255, 8'd70, 8'd0, 8'd59, 8'd60, 8'd255,
                                               8'd1, 8'd30, 8'd59, 8'd0};
  localparam logic signed [31:0] EDGE_KEYS [4] = '{32'sh8000_0000, 32'sh7fff_ffff,
                                                  32'sh0000_0000, -32'sd1};

  logic       clk    = 1'b0;
  logic       rst    = 1'b1;
  logic       steady = 1'b0;
  logic [7:0] cur_threshold;
  int         failures;
  int         pending;
  int         quiet_cycles = 0;

  spdf_in_if  in_ch ();
  spdf_out_if out_ch ();
  spdf_cfg_if cfg_ch ();

  senior_priority_dual_fifo_unit u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg_ch)
  );

  spdf_checker u_checker (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg      (cfg_ch),
    .failures (failures),
    .pending  (pending)
  );

  always #2 clk = ~clk;

  // Stall the result side at random, except in a steady stretch
  always @(posedge clk) begin
    out_ch.ready <= steady || ($urandom_range(0, 99) >= 25);
  end

  // Abort when no beat moves on any channel for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("senior_priority_dual_fifo_unit test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one request, idling first at random, and hold it until taken
  task automatic send_request(input logic [1:0] f, input logic signed [31:0] k,
                              input logic [7:0] a, input logic [9:0] w, input logic [39:0] s);
    while (!steady && $urandom_range(0, 99) < 25) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.func         <= f;
    in_ch.key          <= k;
    in_ch.age          <= a;
    in_ch.weight       <= w;
    in_ch.salary_cents <= s;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Random request; ages cluster round the threshold so both routes get exercised
  task automatic random_request(input int insert_pct);
    int         pick;
    logic [1:0] f;
    logic [7:0] a;
    pick = $urandom_range(0, 99);
    if (pick < insert_pct) f = FN_INSERT;
    else if (pick >= 96) f = FN_UNUSED;
    else if (pick[0]) f = FN_POP_PRIO;
    else f = FN_POP_NORM;
    case ($urandom_range(0, 9))
      0:       a = 8'd0;
      1:       a = 8'd255;
      2, 3, 4: a = cur_threshold + 8'($urandom_range(0, 2)) - 8'd1;
      default: a = 8'($urandom);
    endcase
    send_request(f, $urandom, a, 10'($urandom), {8'($urandom), 32'($urandom)});
  endtask

  // Write the age threshold; only called while the block is idle
  task automatic write_threshold(input logic [7:0] v);
    cur_threshold = v;
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // Hold the request side until every outstanding result has been taken
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // One random phase under a fixed threshold; insert bias shifts every 32 beats
  task automatic run_phase(input logic [7:0] thr, input logic calm, input logic hold_midway);
    int insert_pct;
    wait_drained();
    write_threshold(thr);
    steady <= calm;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (i % 32 == 0) insert_pct = $urandom_range(20, 80);
      if (hold_midway && i == PHASE_ITEMS / 2) wait_drained();
      random_request(insert_pct);
    end
  endtask

  initial begin
    in_ch.valid        <= 1'b0;
    in_ch.func         <= FN_INSERT;
    in_ch.key          <= '0;
    in_ch.age          <= '0;
    in_ch.weight       <= '0;
    in_ch.salary_cents <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.data        <= '0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    write_threshold(AGE_THRESHOLD_RESET);

    // Empty pops and the spare code on empty queues
    send_request(FN_POP_PRIO, $urandom, 8'd255, 10'h3ff, 40'hff_ffff_ffff);
    send_request(FN_POP_NORM, $urandom, 8'd0, 10'h0, 40'h0);
    send_request(FN_UNUSED, $urandom, 8'd60, 10'h155, 40'h55_5555_5555);

    // Fill the priority queue, then fill the normal queue with a mix of eligible and young records
    for (int i = 0; i < 16; i++) begin
      send_request(FN_INSERT, (i < 4) ? EDGE_KEYS[i] : $urandom, DIRECTED_AGES[i],
                   i[0] ? 10'h3ff : 10'h0, i[1] ? 40'hff_ffff_ffff : 40'h0);
    end

    // Both queues full: reject eligible and young records, then drain one of each
    send_request(FN_INSERT, $urandom, 8'd90, 10'd70, 40'd1234567);
    send_request(FN_INSERT, $urandom, 8'd10, 10'd30, 40'd7654321);
    send_request(FN_UNUSED, $urandom, 8'd0, 10'h0, 40'h0);
    send_request(FN_POP_PRIO, $urandom, 8'd0, 10'h0, 40'h0);
    send_request(FN_POP_NORM, $urandom, 8'd0, 10'h0, 40'h0);

    // Random phases across threshold extremes and interior values
    run_phase(8'd0, 1'b0, 1'b0);
    run_phase(8'd255, 1'b1, 1'b0);
    run_phase(8'($urandom_range(1, 254)), 1'b0, 1'b1);
    run_phase(8'($urandom_range(1, 254)), 1'b0, 1'b0);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("senior_priority_dual_fifo_unit test passed");
    end else begin
      $display("senior_priority_dual_fifo_unit test failed");
    end
    $finish;
  end

endmodule
